// ===== rtl/cpbf_pkg.sv =====
// Shared types, operation codes and helpers for the character position bitmap filter.
// No dependencies; imported by char_position_bitmap_filter.
`default_nettype none

package cpbf_pkg;

	// Default sizing
	localparam int DEF_PACKS     = 256;
	localparam int DEF_POSITIONS = 8;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_POSITIONS_USED = 1'b0;   // register index bit paddr[2]
	localparam logic [3:0] POSITIONS_USED_RST = 4'd8;

	// Bitmap geometry
	localparam int ROW_W  = 256;
	localparam int WORD_W = 64;
	localparam int WORDS  = ROW_W / WORD_W;
	localparam int WCNT_W = 7;
	localparam int CNT_W  = 9;

	// Operation codes
	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_INSERT = 3'd1;
	localparam logic [2:0] OP_EXACT  = 3'd2;
	localparam logic [2:0] OP_LIKE   = 3'd3;
	localparam logic [2:0] OP_RANGE  = 3'd4;
	localparam logic [2:0] OP_COUNT  = 3'd5;

	// Pattern characters
	localparam logic [7:0] CH_PERCENT    = 8'h25;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_MAX        = 8'hFF;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] pack_id;
		logic [7:0] position;
		logic [7:0] character;
		logic [7:0] char_high;
		logic       low_given;
		logic       high_given;
		logic       char_valid;
		logic [7:0] escape_char;
		logic       last_item;
	} in_item_t;

	typedef struct packed {
		logic             verdict;
		logic [CNT_W-1:0] bit_count;
	} out_item_t;

	// Population count of one 64-bit word
	function automatic logic [WCNT_W-1:0] popcount_word(input logic [WORD_W-1:0] w);
		logic [WCNT_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_W; i++) begin
			n = n + WCNT_W'(w[i]);
		end
		return n;
	endfunction

	// Mask of the characters in [lo, hi]; empty when lo > hi
	function automatic logic [ROW_W-1:0] range_mask(input logic [7:0] lo, input logic [7:0] hi);
		logic [ROW_W-1:0] m;
		for (int c = 0; c < ROW_W; c++) begin
			m[c] = (8'(c) >= lo) && (8'(c) <= hi);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/char_position_bitmap_filter.sv =====
// Character position bitmap filter: one 256-bit presence row per pack and position.
// A query result is registered from ST_EVAL, a count result from ST_CNT after ST_EVAL
// registers the per-word counts; one item in flight, so in_ready stays low until the
// read-modify-write of the single bitmap memory, a count or a clear walk is done;
// a held result stalls input. Reset: flags and control clear at once, then a clearing pass
// over all PACKS*POSITIONS rows zeroes the memory while in_ready stays low. Uses cpbf_pkg.
`default_nettype none

module char_position_bitmap_filter #(
	parameter int PACKS     = cpbf_pkg::DEF_PACKS,
	parameter int POSITIONS = cpbf_pkg::DEF_POSITIONS
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire cpbf_pkg::in_item_t           in_data,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output cpbf_pkg::out_item_t               out_data,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [cpbf_pkg::PADDR_W-1:0] paddr,
	input  wire logic [cpbf_pkg::PDATA_W-1:0] pwdata,
	output logic      [cpbf_pkg::PDATA_W-1:0] prdata,
	output logic                              pready
);
	import cpbf_pkg::*;

	localparam int DEPTH  = PACKS * POSITIONS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int POS_W  = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

	typedef enum logic [4:0] {
		ST_INIT = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_EVAL = 5'b00100,
		ST_CNT  = 5'b01000,
		ST_CLR  = 5'b10000
	} state_t;

	state_t state_q;

	logic [3:0]        positions_used_q;
	logic              query_failed_q;
	logic              pattern_stopped_q;
	in_item_t          item_q;
	logic              tracked_q;
	logic              rd_ok_q;
	logic [ADDR_W-1:0] row_addr_q;
	logic [ADDR_W-1:0] walk_addr_q;
	logic [POS_W-1:0]  walk_cnt_q;
	logic [WCNT_W-1:0] word_cnt_s2 [WORDS];
	logic              out_valid_q;
	out_item_t         out_data_q;

	// Bitmap memory
	logic [ROW_W-1:0]  mem [DEPTH];
	logic [ROW_W-1:0]  mem_rd_q;
	logic              mem_re;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ROW_W-1:0]  mem_wdata;

	// Accept-side decode
	logic              accept;
	logic              in_pack_ok;
	logic              in_tracked;
	logic [ADDR_W-1:0] in_base;
	logic [ADDR_W-1:0] in_row_addr;

	// Evaluation
	logic [ROW_W-1:0]  row;
	logic              char_bit;
	logic              valid_trk;
	logic              fail_n;
	logic              stop_n;
	logic [7:0]        range_lo;
	logic [7:0]        range_hi;
	logic              range_any;
	logic              out_free;
	logic              out_load;
	logic              cfg_wr;
	logic [CNT_W-1:0]  cnt_sum;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Decode the incoming item's row
	assign in_pack_ok = (32'(in_data.pack_id) < PACKS);
	assign in_tracked = (in_data.position < 8'(positions_used_q)) &&
		(32'(in_data.position) < POSITIONS);
	assign in_base     = ADDR_W'(in_data.pack_id) * ADDR_W'(POSITIONS);
	assign in_row_addr = (in_data.operation == OP_RANGE) ? in_base :
		in_base + ADDR_W'(in_data.position[POS_W-1:0]);

	// Evaluate the row read for the held item
	assign row       = rd_ok_q ? mem_rd_q : '0;
	assign char_bit  = row[item_q.character];
	assign valid_trk = item_q.char_valid && tracked_q;
	assign range_lo  = item_q.low_given ? item_q.character : 8'd0;
	assign range_hi  = item_q.high_given ? item_q.char_high : CH_MAX;
	assign range_any = |(row & range_mask(range_lo, range_hi));

	always_comb begin
		fail_n = query_failed_q;
		stop_n = pattern_stopped_q;
		if (item_q.operation == OP_EXACT && valid_trk && !char_bit) begin
			fail_n = 1'b1;
		end
		if (item_q.operation == OP_LIKE && valid_trk && !pattern_stopped_q) begin
			if (item_q.character == CH_PERCENT || item_q.character == item_q.escape_char) begin
				stop_n = 1'b1;
			end else if (item_q.character != CH_UNDERSCORE && !char_bit) begin
				fail_n = 1'b1;
			end
		end
	end

	assign cnt_sum = CNT_W'(word_cnt_s2[0]) + CNT_W'(word_cnt_s2[1]) +
		CNT_W'(word_cnt_s2[2]) + CNT_W'(word_cnt_s2[3]);

	// Load a result beat when the item is done and the output register is free
	assign out_load = out_free && (
		((state_q == ST_EVAL) &&
			((((item_q.operation == OP_EXACT) || (item_q.operation == OP_LIKE)) &&
				item_q.last_item) || (item_q.operation == OP_RANGE))) ||
		(state_q == ST_CNT));

	// Memory access steering
	always_comb begin
		mem_re    = accept && (in_data.operation == OP_INSERT || in_data.operation == OP_EXACT ||
			in_data.operation == OP_LIKE || in_data.operation == OP_RANGE ||
			in_data.operation == OP_COUNT);
		mem_we    = 1'b0;
		mem_waddr = walk_addr_q;
		mem_wdata = '0;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				mem_we = 1'b1;
			end
			ST_EVAL: begin
				if (item_q.operation == OP_INSERT && valid_trk && rd_ok_q) begin
					mem_we    = 1'b1;
					mem_waddr = row_addr_q;
					mem_wdata = mem_rd_q | (ROW_W'(1) << item_q.character);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rd_q <= mem[in_row_addr];
		end
	end

	// Hold the accepted item and its row address
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= in_data;
			tracked_q  <= in_tracked;
			rd_ok_q    <= in_pack_ok && (in_tracked || in_data.operation == OP_RANGE);
			row_addr_q <= in_row_addr;
		end
	end

	// Per-word population counts of the row
	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			for (int w = 0; w < WORDS; w++) begin
				word_cnt_s2[w] <= popcount_word(row[w*WORD_W +: WORD_W]);
			end
		end
	end

	// Sequencer, flags and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_INIT;
			query_failed_q    <= 1'b0;
			pattern_stopped_q <= 1'b0;
			walk_addr_q       <= '0;
			walk_cnt_q        <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			// Hold the result beat until taken, load a new one when done
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			unique case (state_q)
				ST_INIT: begin
					walk_addr_q <= walk_addr_q + ADDR_W'(1);
					if (walk_addr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (in_data.operation == OP_CLEAR) begin
							walk_addr_q <= in_base;
							walk_cnt_q  <= '0;
							state_q     <= in_pack_ok ? ST_CLR : ST_IDLE;
						end else begin
							state_q <= ST_EVAL;
						end
					end
				end
				ST_CLR: begin
					walk_addr_q <= walk_addr_q + ADDR_W'(1);
					walk_cnt_q  <= walk_cnt_q + POS_W'(1);
					if (walk_cnt_q == POS_W'(POSITIONS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EVAL: begin
					case (item_q.operation)
						OP_EXACT, OP_LIKE: begin
							if (!item_q.last_item) begin
								query_failed_q    <= fail_n;
								pattern_stopped_q <= stop_n;
								state_q           <= ST_IDLE;
							end else if (out_free) begin
								out_data_q.verdict   <= !fail_n;
								out_data_q.bit_count <= '0;
								query_failed_q       <= 1'b0;
								pattern_stopped_q    <= 1'b0;
								state_q              <= ST_IDLE;
							end
						end
						OP_RANGE: begin
							if (out_free) begin
								out_data_q.verdict   <= range_any;
								out_data_q.bit_count <= '0;
								state_q              <= ST_IDLE;
							end
						end
						OP_COUNT: begin
							state_q <= ST_CNT;
						end
						default: begin
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_CNT: begin
					if (out_free) begin
						out_data_q.verdict   <= (cnt_sum != '0);
						out_data_q.bit_count <= cnt_sum;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	// Configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POSITIONS_USED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			positions_used_q <= POSITIONS_USED_RST;
		end else if (cfg_wr) begin
			positions_used_q <= pwdata[3:0];
		end
	end

	assign prdata = (paddr[2] == REG_POSITIONS_USED) ? PDATA_W'(positions_used_q) : '0;

endmodule

`default_nettype wire

// ===== tb/sv/char_position_bitmap_filter_test.sv =====
// Self-checking testbench for char_position_bitmap_filter: directed beats, then random
// string ingest and query traffic checked against an in-bench bitmap filter model.
// Depends on cpbf_pkg and the char_position_bitmap_filter RTL.
`timescale 1ns / 1ps

module char_position_bitmap_filter_test;
	import cpbf_pkg::*;

	localparam int NPACK       = DEF_PACKS;
	localparam int NPOS        = DEF_POSITIONS;
	localparam int DIR_ROWS    = 25;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 190;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG    = 20000;

	// Codes the block leaves unused
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	in_item_t          in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	out_item_t         out_data;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic              pready;

	// Model state: presence rows, pending query flags, tracked position count
	logic [ROW_W-1:0] char_rows [0:NPACK-1][0:NPOS-1];
	logic             pend_miss;
	logic             pend_stop;
	logic [3:0]       tracked_cnt;

	out_item_t verdict_q [$];
	out_item_t want_r;
	int        mismatches = 0;
	int        items_sent = 0;
	int        idle_cycles = 0;
	bit        calm = 1'b0;
	bit        hold_req = 1'b0;
	int        sink_gap = 0;

	// Recently inserted strings, reused by queries
	logic [7:0] saved_str [0:7][0:11];
	int         saved_len [0:7];
	logic [7:0] saved_pack [0:7];

	char_position_bitmap_filter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// Clear the model to its post-reset state
	function automatic void model_reset();
		for (int p = 0; p < NPACK; p++) begin
			for (int q = 0; q < NPOS; q++) begin
				char_rows[p][q] = '0;
			end
		end
		pend_miss = 1'b0;
		pend_stop = 1'b0;
		tracked_cnt = POSITIONS_USED_RST;
		for (int s = 0; s < 8; s++) begin
			saved_len[s] = 0;
			saved_pack[s] = '0;
		end
	endfunction

	// Advance the model by one beat; report whether it yields a verdict
	function automatic void filter_verdict(input in_item_t it, output bit has,
			output out_item_t res);
		int           eff;
		logic         tracked;
		logic         hit;
		logic [7:0]   lo;
		logic [7:0]   hi;
		logic [ROW_W-1:0] row;
		has = 1'b0;
		res = '0;
		eff = (int'(tracked_cnt) > NPOS) ? NPOS : int'(tracked_cnt);
		tracked = int'(it.position) < eff;
		row = (int'(it.position) < NPOS) ? char_rows[it.pack_id][it.position] : '0;
		hit = row[it.character];
		case (it.operation)
		OP_CLEAR: begin
			for (int q = 0; q < NPOS; q++) begin
				char_rows[it.pack_id][q] = '0;
			end
		end
		OP_INSERT: begin
			if (it.char_valid && tracked)
				char_rows[it.pack_id][it.position][it.character] = 1'b1;
		end
		OP_EXACT, OP_LIKE: begin
			if (it.char_valid && tracked) begin
				if (it.operation == OP_EXACT) begin
					if (!hit)
						pend_miss = 1'b1;
				end else if (!pend_stop) begin
					// '%' or the escape character ends the prefix check
					if (it.character == CH_PERCENT || it.character == it.escape_char)
						pend_stop = 1'b1;
					else if (it.character != CH_UNDERSCORE && !hit)
						pend_miss = 1'b1;
				end
			end
			if (it.last_item) begin
				has = 1'b1;
				res.verdict = !pend_miss;
				pend_miss = 1'b0;
				pend_stop = 1'b0;
			end
		end
		OP_RANGE: begin
			lo = it.low_given ? it.character : 8'h00;
			hi = it.high_given ? it.char_high : CH_MAX;
			hit = 1'b0;
			for (int c = 0; c < ROW_W; c++) begin
				if (c >= int'(lo) && c <= int'(hi) && char_rows[it.pack_id][0][c])
					hit = 1'b1;
			end
			has = 1'b1;
			res.verdict = hit;
		end
		OP_COUNT: begin
			has = 1'b1;
			res.bit_count = tracked ? CNT_W'($countones(row)) : '0;
			res.verdict = res.bit_count != 0;
		end
		default: ;
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_item_t noise_item();
		return in_item_t'($bits(in_item_t)'({$urandom(), $urandom()}));
	endfunction

	function automatic in_item_t beat(input logic [2:0] op, input logic [7:0] pk,
			input logic [7:0] pos, input logic [7:0] ch, input logic [7:0] chh,
			input logic lg, input logic hg, input logic cv, input logic [7:0] esc,
			input logic last);
		in_item_t b;
		b.operation = op;
		b.pack_id = pk;
		b.position = pos;
		b.character = ch;
		b.char_high = chh;
		b.low_given = lg;
		b.high_given = hg;
		b.char_valid = cv;
		b.escape_char = esc;
		b.last_item = last;
		return b;
	endfunction

	// String beat with random filler in the fields the operation ignores
	function automatic in_item_t str_beat(input logic [2:0] op, input logic [7:0] pk,
			input int pos, input logic [7:0] ch, input logic cv, input logic last);
		in_item_t b;
		b = noise_item();
		b.operation = op;
		b.pack_id = pk;
		b.position = 8'(pos);
		b.character = ch;
		b.char_valid = cv;
		b.last_item = last;
		return b;
	endfunction

	function automatic logic [7:0] pick_pack();
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, 5));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 99) < 80)
			return 8'h61 + 8'($urandom_range(0, 3));
		return 8'($urandom_range(0, 255));
	endfunction

	// Directed beats; typed rows carry a verdict that is obvious at a glance
	function automatic void dir_row(input int i, output in_item_t it, output bit typed,
			output out_item_t want);
		typed = 1'b0;
		want = '0;
		case (i)
		0: begin
			it = beat(OP_COUNT, 8'd0, 8'd0, 8'h00, 8'h00, 0, 0, 0, 8'h00, 1);
			typed = 1'b1;
		end
		1: begin
			it = beat(OP_RANGE, 8'd0, 8'd0, 8'h00, 8'hFF, 0, 0, 1, 8'h00, 1);
			typed = 1'b1;
		end
		2: begin
			it = beat(OP_EXACT, 8'd0, 8'd0, 8'h00, 8'h00, 0, 0, 0, 8'h00, 1);
			typed = 1'b1;
			want.verdict = 1'b1;
		end
		3: it = beat(OP_INSERT, 8'd255, 8'd0, 8'h00, 8'hFF, 1, 1, 1, 8'hFF, 0);
		4: it = beat(OP_INSERT, 8'd255, 8'd1, 8'hFF, 8'h00, 0, 0, 1, 8'h00, 1);
		5: it = beat(OP_INSERT, 8'd255, 8'd255, 8'h78, 8'h00, 0, 0, 1, 8'h00, 1);
		6: it = beat(OP_COUNT, 8'd255, 8'd0, 8'h00, 8'h00, 0, 0, 0, 8'h00, 1);
		7: begin
			it = beat(OP_COUNT, 8'd255, 8'd255, 8'hFF, 8'hFF, 1, 1, 1, 8'hFF, 1);
			typed = 1'b1;
		end
		8: it = beat(OP_EXACT, 8'd255, 8'd0, 8'h00, 8'h00, 0, 0, 1, 8'h00, 0);
		9: it = beat(OP_EXACT, 8'd255, 8'd1, 8'hFF, 8'h00, 0, 0, 1, 8'h00, 1);
		10: it = beat(OP_EXACT, 8'd255, 8'd0, 8'h01, 8'h00, 0, 0, 1, 8'h00, 1);
		11: it = beat(OP_LIKE, 8'd255, 8'd0, CH_UNDERSCORE, 8'h00, 0, 0, 1, 8'h00, 0);
		12: it = beat(OP_LIKE, 8'd255, 8'd1, CH_PERCENT, 8'h00, 0, 0, 1, 8'h00, 0);
		13: it = beat(OP_LIKE, 8'd255, 8'd2, 8'h71, 8'h00, 0, 0, 1, 8'h00, 1);
		14: it = beat(OP_LIKE, 8'd255, 8'd0, 8'h7A, 8'h00, 0, 0, 1, 8'h7A, 1);
		15: it = beat(OP_LIKE, 8'd255, 8'd0, 8'h7A, 8'h00, 0, 0, 1, 8'h00, 1);
		16: begin
			it = beat(OP_RANGE, 8'd255, 8'd0, 8'h10, 8'h05, 1, 1, 1, 8'h00, 1);
			typed = 1'b1;
		end
		17: it = beat(OP_RANGE, 8'd255, 8'd0, 8'hFF, 8'h00, 1, 0, 1, 8'h00, 1);
		18: it = beat(OP_RANGE, 8'd255, 8'd0, 8'h00, 8'h00, 0, 1, 1, 8'h00, 1);
		19: it = beat(OP_SPARE_A, 8'd255, 8'd0, 8'h00, 8'h00, 1, 1, 1, 8'h00, 1);
		20: it = beat(OP_SPARE_B, 8'd255, 8'd1, 8'hFF, 8'hFF, 1, 1, 1, 8'hFF, 1);
		21: it = beat(OP_CLEAR, 8'd255, 8'd0, 8'h00, 8'h00, 0, 0, 0, 8'h00, 1);
		22: it = beat(OP_COUNT, 8'd255, 8'd1, 8'h00, 8'h00, 0, 0, 0, 8'h00, 1);
		23: it = beat(OP_EXACT, 8'd255, 8'd255, 8'h61, 8'h00, 0, 0, 1, 8'h00, 1);
		24: begin
			it = beat(OP_COUNT, 8'd128, 8'd7, 8'h00, 8'h00, 0, 0, 0, 8'h00, 1);
			typed = 1'b1;
		end
		default: it = '0;
		endcase
	endfunction

	// Offer one beat, hold it until accepted, then log the expected verdict
	task automatic send_beat(input in_item_t it, input bit typed, input out_item_t want);
		bit        has;
		out_item_t res;
		in_data <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		filter_verdict(it, has, res);
		if (typed)
			res = want;
		if (has)
			verdict_q.push_back(res);
		if (it.operation <= OP_COUNT)
			items_sent++;
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Drop valid and wait for every pending verdict plus the tail of a clear
	task automatic drain();
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [3:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_POSITIONS_USED, 2'b00};
		pwdata <= PDATA_W'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tracked_cnt = v;
	endtask

	task automatic put_string();
		int         slot;
		int         len;
		logic [7:0] pk;
		slot = $urandom_range(0, 7);
		len = $urandom_range(0, 10);
		pk = pick_pack();
		saved_len[slot] = len;
		saved_pack[slot] = pk;
		for (int i = 0; i < len; i++) begin
			saved_str[slot][i] = pick_char();
		end
		if (len == 0)
			send_beat(str_beat(OP_INSERT, pk, 0, 8'h00, 1'b0, 1'b1), 1'b0, '0);
		for (int i = 0; i < len; i++) begin
			send_beat(str_beat(OP_INSERT, pk, i, saved_str[slot][i], 1'b1, i == len - 1),
				1'b0, '0);
		end
	endtask

	// Query a saved string, sometimes on another pack, trimmed, extended or altered
	task automatic query_string(input logic [2:0] op);
		int         slot;
		int         len;
		int         r;
		int         alter_at;
		logic [7:0] pk;
		logic [7:0] ch;
		logic [7:0] esc;
		in_item_t   it;
		slot = $urandom_range(0, 7);
		pk = ($urandom_range(0, 9) < 7) ? saved_pack[slot] : pick_pack();
		len = saved_len[slot];
		r = $urandom_range(0, 9);
		if (r == 0 && len > 0)
			len--;
		else if (r == 1)
			len++;
		alter_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : -1;
		esc = ($urandom_range(0, 9) == 0) ? pick_char() : 8'($urandom_range(0, 255));
		if (len == 0) begin
			it = str_beat(op, pk, 0, 8'h00, 1'b0, 1'b1);
			it.escape_char = esc;
			send_beat(it, 1'b0, '0);
		end
		for (int i = 0; i < len; i++) begin
			ch = (i < saved_len[slot] && i != alter_at) ? saved_str[slot][i] : pick_char();
			if (op == OP_LIKE) begin
				r = $urandom_range(0, 99);
				if (r < 15)
					ch = CH_UNDERSCORE;
				else if (r < 22)
					ch = CH_PERCENT;
			end
			it = str_beat(op, pk, i, ch, $urandom_range(0, 19) != 0, i == len - 1);
			it.escape_char = esc;
			send_beat(it, 1'b0, '0);
		end
	endtask

	task automatic range_query();
		in_item_t it;
		it = noise_item();
		it.operation = OP_RANGE;
		it.pack_id = pick_pack();
		// Bounds near the string alphabet hit both verdicts often
		if ($urandom_range(0, 1) == 1) begin
			it.character = 8'h5E + 8'($urandom_range(0, 8));
			it.char_high = 8'h5E + 8'($urandom_range(0, 8));
		end
		send_beat(it, 1'b0, '0);
	endtask

	task automatic count_query();
		in_item_t it;
		it = noise_item();
		it.operation = OP_COUNT;
		it.pack_id = pick_pack();
		if ($urandom_range(0, 99) < 85)
			it.position = 8'($urandom_range(0, 9));
		send_beat(it, 1'b0, '0);
	endtask

	task automatic random_sequence();
		int       r;
		in_item_t it;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			put_string();
		end else if (r < 50) begin
			query_string(OP_EXACT);
		end else if (r < 65) begin
			query_string(OP_LIKE);
		end else if (r < 77) begin
			range_query();
		end else if (r < 87) begin
			count_query();
		end else if (r < 90) begin
			it = noise_item();
			it.operation = OP_CLEAR;
			it.pack_id = pick_pack();
			send_beat(it, 1'b0, '0);
		end else begin
			send_beat(noise_item(), 1'b0, '0);
		end
	endtask

	function automatic void flag_mismatch(input string what, input out_item_t want,
			input out_item_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s at %0t: expected verdict=%0d count=%0d, got verdict=%0d count=%0d",
				what, $realtime, want.verdict, want.bit_count, got.verdict, got.bit_count);
	endfunction

	// Check each delivered verdict against the oldest pending one
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (verdict_q.size() == 0) begin
				flag_mismatch("unexpected beat", '0, out_data);
			end else begin
				want_r = verdict_q.pop_front();
				if (out_data.verdict !== want_r.verdict || out_data.bit_count !== want_r.bit_count)
					flag_mismatch("verdict", want_r, out_data);
			end
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin : sink
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_req = 1'b0;
			end else if (sink_gap > 0) begin
				out_ready <= 1'b0;
				sink_gap--;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					sink_gap = gap_len();
			end
		end
	end

	// Stop a hung run: too long without any beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		in_item_t   it;
		bit         typed;
		out_item_t  want;
		int         phase_end;
		logic [3:0] setting;
		model_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed beats at the reset setting
		for (int i = 0; i < DIR_ROWS; i++) begin
			dir_row(i, it, typed, want);
			send_beat(it, typed, want);
		end
		drain();

		// Random phases, each under its own tracked position count
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph == 0)
				setting = 4'd1;
			else if (ph == 1)
				setting = 4'd8;
			else
				setting = 4'($urandom_range(1, 8));
			cfg_write(setting);
			calm = (ph % 3 == 2);
			if (ph == 1) begin
				// Back up the block while results are held off
				hold_req = 1'b1;
				calm = 1'b1;
				repeat (40) count_query();
				calm = 1'b0;
			end
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) random_sequence();
			drain();
		end

		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
